/* hdl/ikm_pkg.sv */
// shared types, codes and hash helpers for the integer-key linear-probe map
// no dependencies; imported by every module of the block except ikm_ram
package ikm_pkg;

    localparam int KEY_W      = 32;
    localparam int DATA_W     = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = 1;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_FIND   = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2,
        ST_ZERO    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_PROBE = 2'd0,
        KIND_ZERO  = 2'd1,
        KIND_NOP   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        BK_CLEAR = 2'd0,
        BK_IDLE  = 2'd1,
        BK_PROBE = 2'd2,
        BK_RESP  = 2'd3
    } back_state_t;

    // one classified command travelling from front to back
    typedef struct packed {
        kind_t             kind;
        cmd_t              cmd;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] value;
        logic [KEY_W-1:0]  hash;
    } item_t;

    // one result word
    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] result_value;
        logic [5:0]        slot_index;
        logic [6:0]        occupancy;
    } result_t;

    // first four steps of the key mix
    function automatic logic [KEY_W-1:0] mix_lo(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] a;
        a = k;
        a = a - (a << 6);
        a = a ^ (a >> 17);
        a = a - (a << 9);
        a = a ^ (a << 4);
        return a;
    endfunction

    // last three steps of the key mix
    function automatic logic [KEY_W-1:0] mix_hi(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] a;
        a = k;
        a = a - (a << 3);
        a = a ^ (a << 10);
        a = a ^ (a >> 15);
        return a;
    endfunction

endpackage

/* hdl/ikm_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module ikm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hdl/ikm_front.sv */
// front end: takes a command word, hashes the key with mix_lo then mix_hi, classifies it
// depends on ikm_pkg
module ikm_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    in_command,
    input  logic [31:0]   in_key,
    input  logic [31:0]   in_value,
    output logic          push,
    output ikm_pkg::item_t push_item,
    input  logic          q_full
);
    import ikm_pkg::*;

    logic              hold_reg, hold_next;
    logic              mid_reg, mid_next;
    logic [1:0]        cmd_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [DATA_W-1:0] val_reg;
    logic [KEY_W-1:0]  mix_reg;
    logic              take;

    assign in_ready = !hold_reg;
    assign take     = in_valid && !hold_reg;
    assign push     = mid_reg && !q_full;

    always_comb
    begin
        hold_next = hold_reg;
        mid_next  = mid_reg;
        if (take)
        begin
            hold_next = 1'b1;
            mid_next  = 1'b0;
        end
        else if (push)
        begin
            hold_next = 1'b0;
            mid_next  = 1'b0;
        end
        else if (hold_reg)
        begin
            mid_next = 1'b1;
        end
    end

    always_comb
    begin
        push_item.cmd   = cmd_t'(cmd_reg);
        push_item.key   = key_reg;
        push_item.value = val_reg;
        push_item.hash  = mix_hi(mix_reg);
        if (cmd_t'(cmd_reg) == CMD_NOP)
        begin
            push_item.kind = KIND_NOP;
        end
        else if (key_reg == '0)
        begin
            push_item.kind = KIND_ZERO;
        end
        else
        begin
            push_item.kind = KIND_PROBE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= 1'b0;
            mid_reg  <= 1'b0;
        end
        else
        begin
            hold_reg <= hold_next;
            mid_reg  <= mid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= in_command;
            key_reg <= in_key;
            val_reg <= in_value;
        end
        if (hold_reg && !mid_reg)
        begin
            mix_reg <= mix_lo(key_reg);
        end
    end

endmodule

/* hdl/ikm_queue.sv */
// two-entry queue of classified commands between front and back
// depends on ikm_pkg
module ikm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ikm_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output ikm_pkg::item_t head
);
    import ikm_pkg::*;

    item_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    cnt_reg, cnt_next;

    assign full      = (cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* hdl/ikm_back.sv */
// back end: clears the key store, probes the table, updates it, holds the result word
// depends on ikm_pkg and ikm_ram
module ikm_back #(
    parameter int TABLE_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_not_empty,
    input  ikm_pkg::item_t   q_head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output ikm_pkg::result_t out_result
);
    import ikm_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    back_state_t       state_reg, state_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [AW:0]       iss_reg, iss_next;
    logic [AW:0]       chk_reg, chk_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     pend_slot_reg, pend_slot_next;
    logic [CW-1:0]     occ_reg, occ_next;
    cmd_t              cmd_reg, cmd_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [DATA_W-1:0] val_reg, val_next;
    status_t           st_reg, st_next;
    logic [AW-1:0]     slot_reg, slot_next;
    logic              ov_reg, ov_next;
    result_t           res_reg, res_next;

    logic                   k_wr_en, k_rd_en, v_wr_en, v_rd_en;
    logic [AW-1:0]          k_wr_addr;
    logic [KEY_W-1:0]       k_wr_data, k_rd_data;
    logic [VALUE_WIDTH-1:0] v_rd_data;
    logic [VALUE_WIDTH+31:0] v_in_ext;
    logic [VALUE_WIDTH+31:0] v_out_ext;
    logic [AW+5:0]          slot_ext;
    logic [CW+6:0]          occ_ext;
    logic [KEY_W-1:0]       target;
    logic                   hit, miss, can_issue, resp_go;

    ikm_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
        .clk     (clk),
        .wr_en   (k_wr_en),
        .wr_addr (k_wr_addr),
        .wr_data (k_wr_data),
        .rd_en   (k_rd_en),
        .rd_addr (addr_reg),
        .rd_data (k_rd_data)
    );

    ikm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(TABLE_DEPTH)) u_val_ram (
        .clk     (clk),
        .wr_en   (v_wr_en),
        .wr_addr (pend_slot_reg),
        .wr_data (v_in_ext[VALUE_WIDTH-1:0]),
        .rd_en   (v_rd_en),
        .rd_addr (pend_slot_reg),
        .rd_data (v_rd_data)
    );

    assign v_in_ext  = {{VALUE_WIDTH{1'b0}}, val_reg};
    assign v_out_ext = {32'd0, v_rd_data};
    assign slot_ext  = {6'd0, slot_reg};
    assign occ_ext   = {7'd0, occ_reg};

    // insert hunts for an empty slot, find and remove for the key
    assign target    = (cmd_reg == CMD_INSERT) ? '0 : key_reg;
    assign hit       = (state_reg == BK_PROBE) && pend_reg && (k_rd_data == target);
    assign miss      = (state_reg == BK_PROBE) && pend_reg && !hit
                       && (chk_reg == (AW+1)'(TABLE_DEPTH - 1));
    assign can_issue = (state_reg == BK_PROBE) && !hit && !miss
                       && (iss_reg != (AW+1)'(TABLE_DEPTH));
    assign resp_go   = (state_reg == BK_RESP) && (!ov_reg || out_ready);
    assign pop       = (state_reg == BK_IDLE) && q_not_empty;

    assign out_valid  = ov_reg;
    assign out_result = res_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_CLEAR:
            begin
                if (clr_reg == AW'(TABLE_DEPTH - 1))
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (q_not_empty)
                begin
                    state_next = (q_head.kind == KIND_PROBE) ? BK_PROBE : BK_RESP;
                end
            end
            BK_PROBE:
            begin
                if (hit || miss)
                begin
                    state_next = BK_RESP;
                end
            end
            BK_RESP:
            begin
                if (resp_go)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_CLEAR;
            end
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        clr_next       = clr_reg;
        addr_next      = addr_reg;
        iss_next       = iss_reg;
        chk_next       = chk_reg;
        pend_next      = 1'b0;
        pend_slot_next = pend_slot_reg;
        occ_next       = occ_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        st_next        = st_reg;
        slot_next      = slot_reg;
        ov_next        = ov_reg;
        res_next       = res_reg;
        k_wr_en        = 1'b0;
        k_wr_addr      = pend_slot_reg;
        k_wr_data      = '0;
        k_rd_en        = 1'b0;
        v_wr_en        = 1'b0;
        v_rd_en        = 1'b0;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            BK_CLEAR:
            begin
                k_wr_en   = 1'b1;
                k_wr_addr = clr_reg;
                clr_next  = clr_reg + 1'b1;
            end
            BK_IDLE:
            begin
                if (q_not_empty)
                begin
                    cmd_next  = q_head.cmd;
                    key_next  = q_head.key;
                    val_next  = q_head.value;
                    addr_next = q_head.hash[AW-1:0];
                    iss_next  = '0;
                    chk_next  = '0;
                    slot_next = '0;
                    st_next   = (q_head.kind == KIND_ZERO) ? ST_ZERO : ST_DONE;
                end
            end
            BK_PROBE:
            begin
                if (hit)
                begin
                    st_next   = ST_DONE;
                    slot_next = pend_slot_reg;
                    case (cmd_reg)
                        CMD_INSERT:
                        begin
                            k_wr_en   = 1'b1;
                            k_wr_data = key_reg;
                            v_wr_en   = 1'b1;
                            occ_next  = occ_reg + 1'b1;
                        end
                        CMD_FIND:
                        begin
                            v_rd_en = 1'b1;
                        end
                        CMD_REMOVE:
                        begin
                            k_wr_en = 1'b1;
                            if (occ_reg != '0)
                            begin
                                occ_next = occ_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            st_next = ST_DONE;
                        end
                    endcase
                end
                else if (miss)
                begin
                    st_next   = (cmd_reg == CMD_INSERT) ? ST_FULL : ST_MISSING;
                    slot_next = '0;
                end
                else
                begin
                    if (pend_reg)
                    begin
                        chk_next = chk_reg + 1'b1;
                    end
                    if (can_issue)
                    begin
                        k_rd_en        = 1'b1;
                        pend_next      = 1'b1;
                        pend_slot_next = addr_reg;
                        addr_next      = addr_reg + 1'b1;
                        iss_next       = iss_reg + 1'b1;
                    end
                end
            end
            BK_RESP:
            begin
                if (resp_go)
                begin
                    ov_next                = 1'b1;
                    res_next.status        = st_reg;
                    res_next.slot_index    = slot_ext[5:0];
                    res_next.occupancy     = occ_ext[6:0];
                    res_next.result_value  = '0;
                    if (cmd_reg == CMD_FIND && st_reg == ST_DONE)
                    begin
                        res_next.result_value = v_out_ext[31:0];
                    end
                end
            end
            default:
            begin
                ov_next = ov_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_CLEAR;
            clr_reg   <= '0;
            pend_reg  <= 1'b0;
            occ_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pend_reg  <= pend_next;
            occ_reg   <= occ_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        iss_reg       <= iss_next;
        chk_reg       <= chk_next;
        pend_slot_reg <= pend_slot_next;
        cmd_reg       <= cmd_next;
        key_reg       <= key_next;
        val_reg       <= val_next;
        st_reg        <= st_next;
        slot_reg      <= slot_next;
        res_reg       <= res_next;
    end

endmodule

/* hdl/integer_key_linear_probe_map_core.sv */
// top level of the integer-key linear-probe hash map
// depends on ikm_pkg, ikm_front, ikm_queue, ikm_back and ikm_ram
//
// usage
// - s_axis carries one command word: insert, find or remove on a 32-bit key, with
//   a data word stored on insert; m_axis returns exactly one result word for each
// - the front hashes the key with mix_lo then mix_hi and queues the classified command;
//   the back walks the key store one slot per cycle from the hashed start slot
// - a command passes through the front hash, the queue, the back's pick-up from the
//   queue, a probe walk over up to TABLE_DEPTH slots and the result register
// - the back takes the next command only after it has answered the last one, held
//   up by the probe walk over the key ram read port, one slot read per cycle
// - zero keys and the unused command code skip the probe; the back goes from the
//   queue straight to loading their result word
// - after reset the back clears the key store slot by slot; the
//   front still takes and queues words meanwhile, the back starts after it
// - a stalled m_axis holds its word; the back keeps one finished result waiting
//   and the queue plus front take up to three more words before s_axis stalls
module integer_key_linear_probe_map_core #(
    parameter int TABLE_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // command[1:0], key[33:2], value[65:34], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // status[1:0], result_value[33:2],
                                        // slot_index[39:34], occupancy[46:40], zero pad
);
    import ikm_pkg::*;

    logic    push, q_full, q_not_empty, pop;
    item_t   push_item, q_head;
    result_t res;

    // front: hash and classify each command word
    ikm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_command (s_axis_tdata[1:0]),
        .in_key     (s_axis_tdata[33:2]),
        .in_value   (s_axis_tdata[65:34]),
        .push       (push),
        .push_item  (push_item),
        .q_full     (q_full)
    );

    // short queue decoupling front and back
    ikm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // back: probe walk, table update and result register
    ikm_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_result  (res)
    );

    // pack result word, lowest field first
    assign m_axis_tdata = {1'b0, res.occupancy, res.slot_index, res.result_value, res.status};

endmodule
